/* sv/gsaw_pkg.sv */
// Shared types and constants for the grid self-avoiding walk block.
`default_nettype none

package gsaw_pkg;

    localparam int ROW_W     = 6;
    localparam int COL_W     = 5;
    localparam int LEN_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [ROW_W-1:0] START_ROW_RST = 6'd11;
    localparam logic [COL_W-1:0] START_COL_RST = 5'd10;
    localparam logic [LEN_W-1:0] MIN_LEN_RST   = 10'd300;
    localparam logic [LEN_W-1:0] LEN_MAX       = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 2'd2;

    localparam logic ACT_RESTART = 1'b0;
    localparam logic ACT_STEP    = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef struct packed {
        logic [ROW_W-1:0] start_row;
        logic [COL_W-1:0] start_col;
        logic [LEN_W-1:0] len_goal;
    } t_cfg;

    typedef struct packed {
        logic             moved;
        t_dir             direction;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [LEN_W-1:0] length;
        logic             stuck;
        logic             long_enough;
    } t_result;

endpackage

`default_nettype wire

/* sv/grid_self_avoiding_walk.sv */
// Top level of the grid self-avoiding walk block.
// A result word is registered in the output buffer once its input is accepted.
// Throughput: one word per cycle unless the skid register is full; the step
// logic reads a five-row visited-map window held in registers, refilled from a row RAM.
// Reset is synchronous and places the walker on the start cell with an empty
// map at once; per-row valid bits replace any clearing pass.
`default_nettype none

module grid_self_avoiding_walk
    import gsaw_pkg::*;
#(
    parameter int GRID_ROWS = 36,
    parameter int GRID_COLS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_action,
    input  wire logic [1:0]           i_rand_dir,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_moved,
    output logic      [1:0]           o_direction,
    output logic      [ROW_W-1:0]     o_row,
    output logic      [COL_W-1:0]     o_col,
    output logic      [LEN_W-1:0]     o_length,
    output logic                      o_stuck,
    output logic                      o_long_enough,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_result core_res, out_res;
    logic    go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_row <= START_ROW_RST;
            r_cfg.start_col <= START_COL_RST;
            r_cfg.len_goal  <= MIN_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_ROW: r_cfg.start_row <= i_cfg_data[ROW_W-1:0];
                CFG_START_COL: r_cfg.start_col <= i_cfg_data[COL_W-1:0];
                CFG_MIN_LEN:   r_cfg.len_goal  <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign go = i_in_valid && o_in_ready;

    gsaw_core #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_action   (i_action),
        .i_rand_dir (i_rand_dir),
        .i_cfg      (r_cfg),
        .o_res      (core_res)
    );

    gsaw_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (go),
        .o_ready (o_in_ready),
        .i_data  (core_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_moved       = out_res.moved;
    assign o_direction   = out_res.direction;
    assign o_row         = out_res.row;
    assign o_col         = out_res.col;
    assign o_length      = out_res.length;
    assign o_stuck       = out_res.stuck;
    assign o_long_enough = out_res.long_enough;

endmodule

`default_nettype wire

/* sv/gsaw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module gsaw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 36
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/gsaw_core.sv */
// Walk state, five-row window of the visited map and the step decision.
`default_nettype none

module gsaw_core
    import gsaw_pkg::*;
#(
    parameter int GRID_ROWS = 36,
    parameter int GRID_COLS = 24
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_go,
    input  wire logic       i_action,
    input  wire logic [1:0] i_rand_dir,
    input  wire t_cfg       i_cfg,
    output t_result         o_res
);

    localparam int RW  = $clog2(GRID_ROWS);
    localparam int CW  = $clog2(GRID_COLS);
    localparam int WIN = 5;
    localparam int CTR = 2;

    function automatic int clamp_int(input int v, input int hi);
        return (v > hi) ? hi : v;
    endfunction

    localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);
    localparam logic [RW-1:0] RST_ROW  = RW'(clamp_int(int'(START_ROW_RST), GRID_ROWS - 1));
    localparam logic [CW-1:0] RST_COL  = CW'(clamp_int(int'(START_COL_RST), GRID_COLS - 1));
    localparam logic [GRID_COLS-1:0] BIT0 = GRID_COLS'(1);

    logic [RW-1:0]        r_row, n_row, mv_row, start_row;
    logic [CW-1:0]        r_col, n_col, mv_col, start_col, col_p1, col_m1;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_ended, n_ended;
    logic [GRID_COLS-1:0] r_win [WIN];
    logic [GRID_COLS-1:0] n_win [WIN];
    logic [GRID_COLS-1:0] e_win [WIN];
    logic                 r_pend_top, n_pend_top, r_pend_bot, n_pend_bot;
    logic                 r_rd_ok, n_rd_ok;
    logic [GRID_ROWS-1:0] r_row_vld, n_row_vld;
    logic [GRID_COLS-1:0] rd_data, rd_row, cen_row;
    logic [3:0]           nb_ok;
    logic [2:0]           nb_cnt;
    t_dir                 only_dir, dir;
    logic                 moved, dec_end, step_move;
    logic                 ram_we;
    logic [RW-1:0]        ram_waddr, ram_raddr;
    logic [GRID_COLS-1:0] ram_wdata;

    gsaw_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Neighbor check and direction choice.
    always_comb begin
        rd_row = r_rd_ok ? rd_data : '0;
        for (int k = 0; k < WIN; k++) begin
            e_win[k] = r_win[k];
        end
        if (r_pend_top) begin
            e_win[0] = rd_row;
        end
        if (r_pend_bot) begin
            e_win[WIN-1] = rd_row;
        end

        col_p1 = r_col + 1'b1;
        col_m1 = r_col - 1'b1;
        nb_ok[DIR_UP]    = (r_row != '0)       && !e_win[CTR-1][r_col];
        nb_ok[DIR_RIGHT] = (r_col != COL_LAST) && !e_win[CTR][col_p1];
        nb_ok[DIR_DOWN]  = (r_row != ROW_LAST) && !e_win[CTR+1][r_col];
        nb_ok[DIR_LEFT]  = (r_col != '0)       && !e_win[CTR][col_m1];
        nb_cnt = 3'($countones(nb_ok));

        priority if (nb_ok[DIR_LEFT]) begin
            only_dir = DIR_LEFT;
        end else if (nb_ok[DIR_DOWN]) begin
            only_dir = DIR_DOWN;
        end else if (nb_ok[DIR_RIGHT]) begin
            only_dir = DIR_RIGHT;
        end else begin
            only_dir = DIR_UP;
        end

        moved   = 1'b0;
        dir     = DIR_UP;
        dec_end = 1'b0;
        priority if (nb_cnt == 3'd0) begin
            dec_end = 1'b1;
        end else if (nb_cnt == 3'd1) begin
            moved = 1'b1;
            dir   = only_dir;
        end else if (nb_ok[i_rand_dir]) begin
            moved = 1'b1;
            dir   = t_dir'(i_rand_dir);
        end

        mv_row = r_row;
        mv_col = r_col;
        unique case (dir)
            DIR_UP: begin
                mv_row  = r_row - 1'b1;
                cen_row = e_win[CTR-1] | (BIT0 << r_col);
            end
            DIR_RIGHT: begin
                mv_col  = col_p1;
                cen_row = e_win[CTR] | (BIT0 << col_p1);
            end
            DIR_DOWN: begin
                mv_row  = r_row + 1'b1;
                cen_row = e_win[CTR+1] | (BIT0 << r_col);
            end
            DIR_LEFT: begin
                mv_col  = col_m1;
                cen_row = e_win[CTR] | (BIT0 << col_m1);
            end
        endcase
    end

    // Next state of the walk, the window and the map rows in RAM.
    always_comb begin
        start_row  = RW'(clamp_int(int'(i_cfg.start_row), GRID_ROWS - 1));
        start_col  = CW'(clamp_int(int'(i_cfg.start_col), GRID_COLS - 1));
        step_move  = i_go && (i_action == ACT_STEP) && moved;
        n_row      = r_row;
        n_col      = r_col;
        n_len      = r_len;
        n_ended    = r_ended;
        n_pend_top = 1'b0;
        n_pend_bot = 1'b0;
        n_rd_ok    = 1'b0;
        n_row_vld  = r_row_vld;
        ram_we     = 1'b0;
        ram_waddr  = r_row;
        ram_wdata  = e_win[0];
        ram_raddr  = r_row;
        for (int k = 0; k < WIN; k++) begin
            n_win[k] = e_win[k];
        end

        if (i_go && (i_action == ACT_RESTART)) begin
            n_row     = start_row;
            n_col     = start_col;
            n_len     = '0;
            n_ended   = 1'b0;
            n_row_vld = '0;
            for (int k = 0; k < WIN; k++) begin
                n_win[k] = '0;
            end
            n_win[CTR] = BIT0 << start_col;
        end else if (i_go) begin
            n_ended = r_ended | dec_end;
            if (moved) begin
                n_row = mv_row;
                n_col = mv_col;
                if (r_len != LEN_MAX) begin
                    n_len = r_len + 1'b1;
                end
                unique case (dir)
                    DIR_UP: begin
                        n_win[1]   = e_win[0];
                        n_win[2]   = cen_row;
                        n_win[3]   = e_win[2];
                        n_win[4]   = e_win[3];
                        n_pend_top = 1'b1;
                        ram_raddr  = RW'(int'(mv_row) - 2);
                        n_rd_ok    = (int'(mv_row) >= 2) && r_row_vld[ram_raddr];
                        ram_waddr  = RW'(int'(r_row) + 2);
                        ram_wdata  = e_win[WIN-1];
                        ram_we     = (int'(r_row) + 2 <= GRID_ROWS - 1);
                        if (ram_we) begin
                            n_row_vld[ram_waddr] = 1'b1;
                        end
                    end
                    DIR_DOWN: begin
                        n_win[0]   = e_win[1];
                        n_win[1]   = e_win[2];
                        n_win[2]   = cen_row;
                        n_win[3]   = e_win[4];
                        n_pend_bot = 1'b1;
                        ram_raddr  = RW'(int'(mv_row) + 2);
                        n_rd_ok    = (int'(mv_row) + 2 <= GRID_ROWS - 1)
                                     && r_row_vld[ram_raddr];
                        ram_waddr  = RW'(int'(r_row) - 2);
                        ram_wdata  = e_win[0];
                        ram_we     = (int'(r_row) >= 2);
                        if (ram_we) begin
                            n_row_vld[ram_waddr] = 1'b1;
                        end
                    end
                    DIR_RIGHT, DIR_LEFT: begin
                        n_win[CTR] = cen_row;
                    end
                endcase
            end
        end

        o_res.moved       = step_move;
        o_res.direction   = step_move ? dir : DIR_UP;
        o_res.row         = ROW_W'(n_row);
        o_res.col         = COL_W'(n_col);
        o_res.length      = n_len;
        o_res.stuck       = n_ended;
        o_res.long_enough = (n_len >= i_cfg.len_goal);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= RST_ROW;
            r_col      <= RST_COL;
            r_len      <= '0;
            r_ended    <= 1'b0;
            r_pend_top <= 1'b0;
            r_pend_bot <= 1'b0;
            r_rd_ok    <= 1'b0;
            r_row_vld  <= '0;
            for (int k = 0; k < WIN; k++) begin
                r_win[k] <= '0;
            end
            r_win[CTR] <= BIT0 << RST_COL;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_len      <= n_len;
            r_ended    <= n_ended;
            r_pend_top <= n_pend_top;
            r_pend_bot <= n_pend_bot;
            r_rd_ok    <= n_rd_ok;
            r_row_vld  <= n_row_vld;
            for (int k = 0; k < WIN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/gsaw_obuf.sv */
// Two-entry output buffer: result register plus skid register.
`default_nettype none

module gsaw_obuf
    import gsaw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_result i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_out_vld, n_out_vld, r_skid_vld, n_skid_vld;
    t_result r_out, n_out, r_skid, n_skid;

    assign o_ready = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (i_valid && o_ready) begin
            if (!r_out_vld || i_ready) begin
                n_out     = i_data;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = i_data;
                n_skid_vld = 1'b1;
            end
        end else if (r_out_vld && i_ready) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

/* sv/gsaw_chk.sv */
// Port-level checker for the grid self-avoiding walk block and its bind.
`default_nettype none

module gsaw_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_moved,
    input wire logic [1:0] o_direction,
    input wire logic [5:0] o_row,
    input wire logic [4:0] o_col,
    input wire logic [9:0] o_length,
    input wire logic       o_stuck,
    input wire logic       o_long_enough
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_moved) && $stable(o_direction) && $stable(o_row)
            && $stable(o_col) && $stable(o_length) && $stable(o_stuck)
            && $stable(o_long_enough))
        else $error("result word changed while stalled");

    // Without a move the direction reads as up.
    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_moved |-> o_direction == 2'd0)
        else $error("direction set on a word without a move");

    // A finished walk never moves.
    a_stuck_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stuck |-> !o_moved)
        else $error("walk moved after it ended");

    // Input backpressure only while a result word is waiting.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind grid_self_avoiding_walk gsaw_chk u_gsaw_chk (.*);

`default_nettype wire

/* sim/tb.sv */
// Testbench for the grid self-avoiding walk block, with a walk tracker that checks every result.
`timescale 1ns / 100ps

module tb
    import gsaw_pkg::*;
();

    localparam int ROWS = 36;
    localparam int COLS = 24;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic                 i_action      = ACT_RESTART;
    logic [1:0]           i_rand_dir    = DIR_UP;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic                 o_moved;
    logic [1:0]           o_direction;
    logic [ROW_W-1:0]     o_row;
    logic [COL_W-1:0]     o_col;
    logic [LEN_W-1:0]     o_length;
    logic                 o_stuck;
    logic                 o_long_enough;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_START_ROW;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    bit               trail [ROWS][COLS];
    logic [ROW_W-1:0] walk_row;
    logic [COL_W-1:0] walk_col;
    logic [LEN_W-1:0] walk_len;
    bit               boxed_in;
    logic [ROW_W-1:0] cfg_row;
    logic [COL_W-1:0] cfg_col;
    logic [LEN_W-1:0] cfg_min_len;
    t_result          pending_results [$];
    int               errors        = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;

    grid_self_avoiding_walk #(
        .GRID_ROWS(ROWS),
        .GRID_COLS(COLS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_rand_dir   (i_rand_dir),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_moved      (o_moved),
        .o_direction  (o_direction),
        .o_row        (o_row),
        .o_col        (o_col),
        .o_length     (o_length),
        .o_stuck      (o_stuck),
        .o_long_enough(o_long_enough),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #4ms;
        $display("status: fail");
        $finish;
    end

    function automatic void restart_tracker();
        walk_row = (cfg_row > ROWS - 1) ? ROW_W'(ROWS - 1) : cfg_row;
        walk_col = (cfg_col > COLS - 1) ? COL_W'(COLS - 1) : cfg_col;
        foreach (trail[r, c]) trail[r][c] = 1'b0;
        trail[walk_row][walk_col] = 1'b1;
        walk_len = '0;
        boxed_in = 1'b0;
    endfunction

    function automatic void track_word(logic act, t_dir offer);
        t_result res;
        bit      free_dir [4];
        int      n_free;
        int      r;
        int      c;
        t_dir    only;
        res = '0;
        only = DIR_UP;
        if (act == ACT_RESTART) begin
            restart_tracker();
        end else begin
            r = walk_row;
            c = walk_col;
            free_dir[DIR_UP]    = r != 0 && !trail[r - 1][c];
            free_dir[DIR_RIGHT] = c != COLS - 1 && !trail[r][c + 1];
            free_dir[DIR_DOWN]  = r != ROWS - 1 && !trail[r + 1][c];
            free_dir[DIR_LEFT]  = c != 0 && !trail[r][c - 1];
            n_free = 0;
            for (int d = 0; d < 4; d++) begin
                if (free_dir[d]) begin
                    n_free++;
                    only = t_dir'(d);
                end
            end
            if (n_free == 0) begin
                boxed_in = 1'b1;
            end else if (n_free == 1) begin
                res.moved = 1'b1;
                res.direction = only;
            end else if (free_dir[offer]) begin
                res.moved = 1'b1;
                res.direction = offer;
            end
            if (res.moved) begin
                case (res.direction)
                    DIR_UP:    r--;
                    DIR_RIGHT: c++;
                    DIR_DOWN:  r++;
                    default:   c--;
                endcase
                trail[r][c] = 1'b1;
                walk_row = ROW_W'(r);
                walk_col = COL_W'(c);
                if (walk_len != LEN_MAX) walk_len++;
            end
        end
        res.row = walk_row;
        res.col = walk_col;
        res.length = walk_len;
        res.stuck = boxed_in;
        res.long_enough = walk_len >= cfg_min_len;
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word, length", o_length, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_moved !== want.moved)
                    report_mismatch("moved", o_moved, want.moved);
                if (o_direction !== want.direction)
                    report_mismatch("direction", o_direction, want.direction);
                if (o_row !== want.row)
                    report_mismatch("row", o_row, want.row);
                if (o_col !== want.col)
                    report_mismatch("col", o_col, want.col);
                if (o_length !== want.length)
                    report_mismatch("length", o_length, want.length);
                if (o_stuck !== want.stuck)
                    report_mismatch("stuck", o_stuck, want.stuck);
                if (o_long_enough !== want.long_enough)
                    report_mismatch("long_enough", o_long_enough, want.long_enough);
            end
        end
    end

    task automatic send_word(logic act, t_dir offer);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_rand_dir <= offer;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_word(act, offer);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic [LEN_W-1:0] min_len);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_START_ROW;
        i_cfg_data <= CFG_W'(row);
        @(posedge i_clk);
        cfg_row = row;
        i_cfg_idx <= CFG_START_COL;
        i_cfg_data <= CFG_W'(col);
        @(posedge i_clk);
        cfg_col = col;
        i_cfg_idx <= CFG_MIN_LEN;
        i_cfg_data <= CFG_W'(min_len);
        @(posedge i_clk);
        cfg_min_len = min_len;
        i_cfg_we <= 1'b0;
    endtask

    // The walker starts on the reset start cell without any restart word.
    task automatic test_reset_start();
        send_word(ACT_STEP, DIR_UP);
        send_word(ACT_STEP, DIR_RIGHT);
        send_word(ACT_STEP, DIR_DOWN);
        send_word(ACT_STEP, DIR_LEFT);
    endtask

    // Three moves box the walker into the corner; the next steps find no way out.
    task automatic test_trap_and_stuck();
        configure(6'd0, 5'd1, 10'd3);
        send_word(ACT_RESTART, DIR_LEFT);
        send_word(ACT_STEP, DIR_DOWN);
        send_word(ACT_STEP, DIR_LEFT);
        send_word(ACT_STEP, DIR_UP);
        send_word(ACT_STEP, DIR_RIGHT);
        send_word(ACT_STEP, DIR_DOWN);
        send_word(ACT_RESTART, DIR_UP);
    endtask

    // After a step into the corner only one neighbor is free, so the offered direction is ignored.
    task automatic test_forced_move();
        send_word(ACT_STEP, DIR_LEFT);
        send_word(ACT_STEP, DIR_UP);
        send_word(ACT_STEP, DIR_LEFT);
    endtask

    // Out-of-range start cells saturate, and offers off the grid leave the walker in place.
    task automatic test_extremes();
        configure(6'h3F, 5'h1F, 10'h3FF);
        send_word(ACT_RESTART, DIR_RIGHT);
        send_word(ACT_STEP, DIR_UP);
        send_word(ACT_STEP, DIR_LEFT);
        configure(6'd35, 5'd23, 10'd0);
        send_word(ACT_RESTART, DIR_DOWN);
        send_word(ACT_STEP, DIR_RIGHT);
        send_word(ACT_STEP, DIR_DOWN);
        send_word(ACT_STEP, DIR_UP);
    endtask

    task automatic test_random_walks(int sender_pct, int receiver_pct, int n_words);
        int               sent;
        int               walk_cap;
        int               walk_words;
        int               tail;
        logic [ROW_W-1:0] row_pick;
        logic [COL_W-1:0] col_pick;
        logic [LEN_W-1:0] len_pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(2) == 0) begin
                row_pick = ($urandom_range(7) == 0) ? ROW_W'($urandom_range(63))
                                                    : ROW_W'($urandom_range(ROWS - 1));
                col_pick = ($urandom_range(7) == 0) ? COL_W'($urandom_range(31))
                                                    : COL_W'($urandom_range(COLS - 1));
                len_pick = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(1023))
                                                    : LEN_W'($urandom_range(150));
                configure(row_pick, col_pick, len_pick);
            end
            send_word(ACT_RESTART, t_dir'($urandom_range(3)));
            sent++;
            walk_cap = $urandom_range(400, 10);
            walk_words = 0;
            tail = $urandom_range(3);
            while (walk_words < walk_cap && sent < n_words) begin
                if ($urandom_range(99) == 0) begin
                    send_word(ACT_RESTART, t_dir'($urandom_range(3)));
                end else begin
                    send_word(ACT_STEP, t_dir'($urandom_range(3)));
                end
                sent++;
                walk_words++;
                if (boxed_in) begin
                    if (tail == 0) break;
                    tail--;
                end
            end
        end
    endtask

    initial begin
        cfg_row = START_ROW_RST;
        cfg_col = START_COL_RST;
        cfg_min_len = MIN_LEN_RST;
        restart_tracker();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_start();
        test_trap_and_stuck();
        test_forced_move();
        test_extremes();
        test_random_walks(17, 73, 530);
        test_random_walks(73, 17, 530);
        test_random_walks(0, 0, 530);
        wait_idle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* grid_self_avoiding_walk.f */
sv/gsaw_pkg.sv
sv/gsaw_ram.sv
sv/gsaw_core.sv
sv/gsaw_obuf.sv
sv/grid_self_avoiding_walk.sv
sv/gsaw_chk.sv
sim/tb.sv
